@@ rtl/discrete_spectrum_sampler_unit_defines.svh @@
// ----------------------------------------------------------------------------
// discrete_spectrum_sampler_unit_defines
// Assertion macros for the spectrum sampler; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DISCRETE_SPECTRUM_SAMPLER_UNIT_DEFINES_SVH
`define DISCRETE_SPECTRUM_SAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define DSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dss assertion failed");

// consequent must hold in the cycle after the antecedent
`define DSS_ASSERT_NEXT(lbl, ante, cons) \
  `DSS_ASSERT(lbl, (ante) |=> (cons))

`else

`define DSS_ASSERT(lbl, prop)

`define DSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/dss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and codes of the discrete spectrum sampler.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int MaxBinsDef = 256;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] energy;
    logic [7:0]  bin_index;
    logic [1:0]  status;
  } res_t;

endpackage

@@ rtl/discrete_spectrum_sampler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discrete_spectrum_sampler_unit
// Inverse-CDF sampler over a table of spectrum bins.
//
//   channel   ports                                    handshake
//   request   in_req_type, in_bin_energy,              start & !busy
//             in_bin_weight, in_uniform_fraction
//   result    out_energy, out_bin_index, out_status    out_strobe, one cycle
//
// clear, append, unused and empty-table sample requests: result in the cycle
// after the request, busy stays low. other sample requests run a binary search
// over the bins, one memory read (S_SEARCH) and one compare (S_CMP) per step,
// then S_FETCH reads the picked bin. busy is high while searching and fetching.
// reset empties the table; memories are not cleared. results cannot be stalled.
// ----------------------------------------------------------------------------
module discrete_spectrum_sampler_unit #(
  parameter int MAX_BINS = dss_pkg::MaxBinsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_bin_energy,
  input  logic [23:0] in_bin_weight,
  input  logic [31:0] in_uniform_fraction,
  output logic        out_strobe,
  output logic [31:0] out_energy,
  output logic [7:0]  out_bin_index,
  output logic [1:0]  out_status
);

  localparam int IdxW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic            tbl_wr_en;
  logic [IdxW-1:0] tbl_wr_addr;
  logic [31:0]     tbl_wr_cum;
  logic [IdxW-1:0] tbl_rd_addr;
  logic [31:0]     tbl_rd_energy;
  logic [31:0]     tbl_rd_cum;
  dss_pkg::res_t   res;

  logic            strobe_r;
  logic [31:0]     energy_r;
  logic [7:0]      bin_index_r;
  logic [1:0]      status_r;

  dss_seq #(
    .MAX_BINS (MAX_BINS)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_bin_energy       (in_bin_energy),
    .in_bin_weight       (in_bin_weight),
    .in_uniform_fraction (in_uniform_fraction),
    .tbl_wr_en           (tbl_wr_en),
    .tbl_wr_addr         (tbl_wr_addr),
    .tbl_wr_cum          (tbl_wr_cum),
    .tbl_rd_addr         (tbl_rd_addr),
    .tbl_rd_energy       (tbl_rd_energy),
    .tbl_rd_cum          (tbl_rd_cum),
    .res                 (res)
  );

  dss_table #(
    .MAX_BINS (MAX_BINS)
  ) u_table (
    .clk       (clk),
    .wr_en     (tbl_wr_en),
    .wr_addr   (tbl_wr_addr),
    .wr_energy (in_bin_energy),
    .wr_cum    (tbl_wr_cum),
    .rd_addr   (tbl_rd_addr),
    .rd_energy (tbl_rd_energy),
    .rd_cum    (tbl_rd_cum)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      energy_r    <= res.energy;
      bin_index_r <= res.bin_index;
      status_r    <= res.status;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_energy    = energy_r;
  assign out_bin_index = bin_index_r;
  assign out_status    = status_r;

endmodule

@@ rtl/dss_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_table
// Bin energy and cumulative weight memories, one write and one read port.
// ----------------------------------------------------------------------------
module dss_table #(
  parameter int MAX_BINS = dss_pkg::MaxBinsDef,
  localparam int IdxW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  logic [31:0]     wr_energy,
  input  logic [31:0]     wr_cum,
  input  logic [IdxW-1:0] rd_addr,
  output logic [31:0]     rd_energy,
  output logic [31:0]     rd_cum
);

  logic [31:0] energy_mem [MAX_BINS];
  logic [31:0] cum_mem    [MAX_BINS];
  logic [31:0] rd_energy_r;
  logic [31:0] rd_cum_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      energy_mem[wr_addr] <= wr_energy;
      cum_mem[wr_addr]    <= wr_cum;
    end
  end

  always_ff @(posedge clk) begin
    rd_energy_r <= energy_mem[rd_addr];
    rd_cum_r    <= cum_mem[rd_addr];
  end

  assign rd_energy = rd_energy_r;
  assign rd_cum    = rd_cum_r;

endmodule

@@ rtl/dss_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_seq
// Request sequencer: table fill, target multiply and lower-bound search
// through one shared compare unit.
// ----------------------------------------------------------------------------
`include "discrete_spectrum_sampler_unit_defines.svh"

module dss_seq #(
  parameter int MAX_BINS = dss_pkg::MaxBinsDef,
  localparam int IdxW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1,
  localparam int CntW = $clog2(MAX_BINS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      in_req_type,
  input  logic [31:0]     in_bin_energy,
  input  logic [23:0]     in_bin_weight,
  input  logic [31:0]     in_uniform_fraction,
  output logic            tbl_wr_en,
  output logic [IdxW-1:0] tbl_wr_addr,
  output logic [31:0]     tbl_wr_cum,
  output logic [IdxW-1:0] tbl_rd_addr,
  input  logic [31:0]     tbl_rd_energy,
  input  logic [31:0]     tbl_rd_cum,
  output dss_pkg::res_t   res
);

  localparam logic [CntW-1:0] CountMax = CntW'(MAX_BINS);

  dss_pkg::state_t state_r, state_nxt;

  logic [CntW-1:0] count_r, count_nxt;
  logic [31:0]     total_r, total_nxt;
  logic [63:0]     target_r, target_nxt;
  logic [IdxW-1:0] lo_r, lo_nxt;
  logic [IdxW-1:0] hi_r, hi_nxt;
  logic [IdxW-1:0] mid_r, mid_nxt;

  logic            accept;
  logic            skip;
  logic            full;
  logic            empty;
  logic [32:0]     sum;
  logic [31:0]     sum_sat;
  logic [63:0]     product;
  logic [IdxW-1:0] mid;
  logic            ge;

  assign accept = start && (state_r == dss_pkg::S_IDLE);
  assign busy   = (state_r != dss_pkg::S_IDLE);
  assign skip   = (in_bin_energy == 32'd0) || (in_bin_weight == 24'd0);
  assign full   = (count_r == CountMax);
  assign empty  = (count_r == '0);

  // running weight sum, saturating
  assign sum     = (empty ? 33'd0 : {1'b0, total_r}) + {9'd0, in_bin_weight};
  assign sum_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign product = {32'd0, in_uniform_fraction} * {32'd0, total_r};
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  // shared compare: cum[mid] * 2^32 >= u * total
  assign ge      = ({tbl_rd_cum, 32'd0} >= target_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dss_pkg::S_IDLE: begin
        if (accept && (in_req_type == dss_pkg::REQ_SAMPLE) && !empty) begin
          state_nxt = dss_pkg::S_SEARCH;
        end
      end
      dss_pkg::S_SEARCH: begin
        state_nxt = (lo_r < hi_r) ? dss_pkg::S_CMP : dss_pkg::S_FETCH;
      end
      dss_pkg::S_CMP:   state_nxt = dss_pkg::S_SEARCH;
      dss_pkg::S_FETCH: state_nxt = dss_pkg::S_IDLE;
      default:          state_nxt = dss_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tbl_wr_en     = 1'b0;
    tbl_wr_addr   = count_r[IdxW-1:0];
    tbl_wr_cum    = sum_sat;
    tbl_rd_addr   = lo_r;
    res.valid     = 1'b0;
    res.energy    = 32'd0;
    res.bin_index = 8'd0;
    res.status    = dss_pkg::ST_OK;
    case (state_r)
      dss_pkg::S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            dss_pkg::REQ_APPEND: begin
              res.valid = 1'b1;
              if (skip) begin
                res.status = dss_pkg::ST_SKIPPED;
              end else if (full) begin
                res.status = dss_pkg::ST_FULL;
              end else begin
                tbl_wr_en = 1'b1;
              end
            end
            dss_pkg::REQ_SAMPLE: begin
              if (empty) begin
                res.valid  = 1'b1;
                res.status = dss_pkg::ST_EMPTY;
              end
            end
            default: res.valid = 1'b1;
          endcase
        end
      end
      dss_pkg::S_SEARCH: begin
        if (lo_r < hi_r) begin
          tbl_rd_addr = mid;
        end
      end
      dss_pkg::S_CMP: tbl_rd_addr = lo_r;
      dss_pkg::S_FETCH: begin
        res.valid     = 1'b1;
        res.energy    = tbl_rd_energy;
        res.bin_index = 8'(lo_r);
      end
      default: tbl_rd_addr = lo_r;
    endcase
  end

  // datapath
  always_comb begin
    count_nxt  = count_r;
    total_nxt  = total_r;
    target_nxt = target_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    case (state_r)
      dss_pkg::S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            dss_pkg::REQ_CLEAR: count_nxt = '0;
            dss_pkg::REQ_APPEND: begin
              if (!skip && !full) begin
                count_nxt = count_r + 1'b1;
                total_nxt = sum_sat;
              end
            end
            dss_pkg::REQ_SAMPLE: begin
              target_nxt = product;
              lo_nxt     = '0;
              hi_nxt     = IdxW'(count_r - 1'b1);
            end
            default: count_nxt = count_r;
          endcase
        end
      end
      dss_pkg::S_SEARCH: mid_nxt = mid;
      dss_pkg::S_CMP: begin
        if (ge) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + 1'b1;
        end
      end
      default: mid_nxt = mid_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dss_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r  <= total_nxt;
    target_r <= target_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
  end

  `DSS_ASSERT(a_search_bounds, (state_r == dss_pkg::S_SEARCH) |-> (lo_r <= hi_r))
  `DSS_ASSERT(a_mid_below_hi, (state_r == dss_pkg::S_CMP) |-> (mid_r < hi_r))
  `DSS_ASSERT(a_no_write_full, tbl_wr_en |-> (count_r != CountMax))
  `DSS_ASSERT_NEXT(a_sample_busy, accept && (in_req_type == dss_pkg::REQ_SAMPLE) && !empty, busy)

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the discrete spectrum sampler: a short table of
// directed requests, then random fill/sample episodes with bursty pacing.
// Each result is checked against a fixed expectation or an in-bench model of the bin table.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          NUM_BINS     = dss_pkg::MaxBinsDef;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          RANDOM_REQS  = 1800;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          NUM_DIRECTED = 25;

  typedef struct packed {
    logic [31:0] energy;
    logic [7:0]  bin_index;
    logic [1:0]  status;
  } spectrum_result_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] energy;
    logic [23:0] weight;
    logic [31:0] frac;
    logic        typed;
    logic [31:0] x_energy;
    logic [7:0]  x_index;
    logic [1:0]  x_status;
  } directed_row_t;

  // typed rows carry a result readable at a glance, the rest go to the model
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h0, 1'b1, 32'h0, 8'h0, dss_pkg::ST_EMPTY},
    '{dss_pkg::REQ_APPEND, 32'h0, 24'h000005, 32'h0, 1'b1, 32'h0, 8'h0, dss_pkg::ST_SKIPPED},
    '{dss_pkg::REQ_APPEND, 32'h1, 24'h0, 32'h0, 1'b1, 32'h0, 8'h0, dss_pkg::ST_SKIPPED},
    '{dss_pkg::REQ_APPEND, 32'hFFFFFFFF, 24'h0, 32'hFFFFFFFF,
      1'b1, 32'h0, 8'h0, dss_pkg::ST_SKIPPED},
    '{REQ_UNUSED, 32'hFFFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_CLEAR, 32'hFFFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF,
      1'b1, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_APPEND, 32'hFFFFFFFF, 24'hFFFFFF, 32'h0, 1'b1, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h0, 1'b1, 32'hFFFFFFFF, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_APPEND, 32'h1, 24'h000001, 32'h0, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_APPEND, 32'h80000000, 24'h800000, 32'h0, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_APPEND, 32'h0000FFFF, 24'hFFFFFF, 32'h0, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h0, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'hFFFFFFFF, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h80000000, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h00000001, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_CLEAR, 32'h0, 24'h0, 32'h0, 1'b1, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h12345678, 1'b1, 32'h0, 8'h0, dss_pkg::ST_EMPTY},
    '{dss_pkg::REQ_APPEND, 32'h00000010, 24'h000001, 32'h0, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_APPEND, 32'h00000020, 24'h000001, 32'h0, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    // total of two: u = one half lands exactly on the first bin's edge
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h80000000, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h80000001, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'h7FFFFFFF, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{REQ_UNUSED, 32'h5A5A5A5A, 24'hA5A5A5, 32'h5A5A5A5A, 1'b1, 32'h0, 8'h0, dss_pkg::ST_OK},
    '{dss_pkg::REQ_SAMPLE, 32'h0, 24'h0, 32'hFFFFFFFF, 1'b0, 32'h0, 8'h0, dss_pkg::ST_OK}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [31:0] in_bin_energy;
  logic [23:0] in_bin_weight;
  logic [31:0] in_uniform_fraction;
  logic        out_strobe;
  logic [31:0] out_energy;
  logic [7:0]  out_bin_index;
  logic [1:0]  out_status;

  discrete_spectrum_sampler_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_bin_energy       (in_bin_energy),
    .in_bin_weight       (in_bin_weight),
    .in_uniform_fraction (in_uniform_fraction),
    .out_strobe          (out_strobe),
    .out_energy          (out_energy),
    .out_bin_index       (out_bin_index),
    .out_status          (out_status)
  );

  // model copy of the bin table
  logic [31:0] bin_energy_model [NUM_BINS];
  logic [31:0] cum_weight_model [NUM_BINS];
  int unsigned bin_count_model;

  spectrum_result_t pending_results[$];
  int mismatch_count;
  int cycle_count;
  int requests_sent;
  int burst_left;
  bit no_gaps;
  int full_seen, empty_seen, skipped_seen, picks_seen;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[discrete_spectrum_sampler_unit] ERROR");
      $finish;
    end
  end

  function automatic spectrum_result_t predict_request(input logic [1:0] req,
                                                       input logic [31:0] e,
                                                       input logic [23:0] w,
                                                       input logic [31:0] u);
    spectrum_result_t res;
    logic [32:0] sum;
    logic [63:0] target;
    int unsigned lo, hi, mid;
    res = '0;
    res.status = dss_pkg::ST_OK;
    case (req)
      dss_pkg::REQ_CLEAR: bin_count_model = 0;
      dss_pkg::REQ_APPEND: begin
        if (e == 32'h0 || w == 24'h0) begin
          res.status = dss_pkg::ST_SKIPPED;
        end else if (bin_count_model >= NUM_BINS) begin
          res.status = dss_pkg::ST_FULL;
        end else begin
          sum = {9'h0, w};
          if (bin_count_model > 0) sum = sum + {1'b0, cum_weight_model[bin_count_model - 1]};
          if (sum[32]) sum = 33'h0_FFFF_FFFF;
          bin_energy_model[bin_count_model] = e;
          cum_weight_model[bin_count_model] = sum[31:0];
          bin_count_model++;
        end
      end
      dss_pkg::REQ_SAMPLE: begin
        if (bin_count_model == 0) begin
          res.status = dss_pkg::ST_EMPTY;
        end else begin
          target = {32'h0, u} * {32'h0, cum_weight_model[bin_count_model - 1]};
          lo = 0;
          hi = bin_count_model - 1;
          // lower bound; last bin taken when nothing qualifies
          while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if ({cum_weight_model[mid], 32'h0} >= target) hi = mid;
            else lo = mid + 1;
          end
          res.energy    = bin_energy_model[lo];
          res.bin_index = lo[7:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // holds start high until the request is taken, then queues its result
  task automatic send_request(input logic [1:0] req, input logic [31:0] e,
                              input logic [23:0] w, input logic [31:0] u,
                              input bit typed, input spectrum_result_t fixed);
    spectrum_result_t pred;
    start               <= 1'b1;
    in_req_type         <= req;
    in_bin_energy       <= e;
    in_bin_weight       <= w;
    in_uniform_fraction <= u;
    do @(posedge clk); while (busy !== 1'b0);
    pred = predict_request(req, e, w, u);
    pending_results.insert(pending_results.size(), typed ? fixed : pred);
    requests_sent++;
  endtask

  task automatic issue(input logic [1:0] req, input logic [31:0] e,
                       input logic [23:0] w, input logic [31:0] u);
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    send_request(req, e, w, u, 1'b0, '0);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    spectrum_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: energy %h index %0d status %0d",
               out_energy, out_bin_index, out_status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_energy !== want.energy) begin
          $error("energy: expected %h, got %h", want.energy, out_energy);
          mismatch_count++;
        end
        if (out_bin_index !== want.bin_index) begin
          $error("bin_index: expected %0d, got %0d", want.bin_index, out_bin_index);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        case (want.status)
          dss_pkg::ST_FULL:    full_seen++;
          dss_pkg::ST_EMPTY:   empty_seen++;
          dss_pkg::ST_SKIPPED: skipped_seen++;
          default:             if (want.energy != 32'h0) picks_seen++;
        endcase
      end
    end
  end

  initial begin : stimulus
    int episodes;
    int n_appends, n_samples, pick, weight_mode;
    bit fill;
    logic [31:0] e, u;
    logic [23:0] w;
    logic [63:0] q;
    int unsigned idx;

    rst_n               <= 1'b0;
    start               <= 1'b0;
    in_req_type         <= dss_pkg::REQ_CLEAR;
    in_bin_energy       <= '0;
    in_bin_weight       <= '0;
    in_uniform_fraction <= '0;
    bin_count_model = 0;
    requests_sent   = 0;
    burst_left      = 0;
    no_gaps         = 1'b0;
    episodes        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(DIRECTED[i].req, DIRECTED[i].energy, DIRECTED[i].weight,
                   DIRECTED[i].frac, DIRECTED[i].typed,
                   {DIRECTED[i].x_energy, DIRECTED[i].x_index, DIRECTED[i].x_status});
    end
    wait_all_results();

    while (requests_sent < NUM_DIRECTED + RANDOM_REQS) begin
      fill        = (episodes == 0) || ($urandom_range(0, 9) == 0);
      no_gaps     = ($urandom_range(0, 3) == 0);
      weight_mode = $urandom_range(0, 3);
      if ($urandom_range(0, 4) != 0) begin
        issue(dss_pkg::REQ_CLEAR, $urandom, 24'($urandom), $urandom);
      end

      // fill episodes run past the table size to reach the full case
      n_appends = fill ? NUM_BINS + $urandom_range(1, 4) : $urandom_range(1, 12);
      for (int k = 0; k < n_appends; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any request code, possibly a zero field
          e = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom;
          w = ($urandom_range(0, 1) == 0) ? 24'h0 : 24'($urandom);
          issue(2'($urandom_range(0, 3)), e, w, $urandom);
        end else begin
          e = $urandom;
          if (e == 32'h0) e = 32'h1;
          case (weight_mode)
            0:       w = 24'($urandom_range(1, 3));
            1:       w = 24'hFFFFFF;
            default: w = 24'($urandom_range(1, 24'hFFFFFF));
          endcase
          issue(dss_pkg::REQ_APPEND, e, w, $urandom);
        end
      end

      n_samples = $urandom_range(4, 24);
      for (int k = 0; k < n_samples; k++) begin
        pick = $urandom_range(0, 7);
        u = $urandom;
        if (pick == 0) u = 32'h0;
        else if (pick == 1) u = 32'hFFFFFFFF;
        else if (pick <= 4 && bin_count_model > 0) begin
          // aim at a bin edge: u = cum_i * 2^32 / total, nudged by one
          idx = $urandom_range(0, bin_count_model - 1);
          q = {cum_weight_model[idx], 32'h0} / {32'h0, cum_weight_model[bin_count_model - 1]};
          if (q > 64'hFFFFFFFF) q = 64'hFFFFFFFF;
          u = q[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
        end
        issue(dss_pkg::REQ_SAMPLE, $urandom, 24'($urandom), u);
      end

      if ($urandom_range(0, 3) == 0) wait_all_results();
      episodes++;
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests in %0d episodes: %0d bins picked, %0d skipped, %0d full, %0d empty",
             requests_sent, episodes, picks_seen, skipped_seen, full_seen, empty_seen);
    if (mismatch_count == 0) begin
      $display("[discrete_spectrum_sampler_unit] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[discrete_spectrum_sampler_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_table.sv
rtl/dss_seq.sv
rtl/discrete_spectrum_sampler_unit.sv
test/tb_top.sv
